// ===== sv/kiss_fd_pkg.sv =====
// shared constants and types for the kiss frame deframer
`default_nettype none

package kiss_fd_pkg;

    // framing bytes
    localparam logic [7:0] KISS_FEND  = 8'hC0;
    localparam logic [7:0] KISS_FESC  = 8'hDB;
    localparam logic [7:0] KISS_TFEND = 8'hDC;
    localparam logic [7:0] KISS_TFESC = 8'hDD;

    // longest payload kept before a frame is dropped as oversized
    localparam int unsigned MAX_PAYLOAD = 508;
    localparam int unsigned LEN_W       = 9;
    localparam int unsigned CNT_W       = 32;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

    // input item kinds carried on tuser
    localparam logic REQ_BYTE    = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    // result item kinds carried on tlast
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_DISCARD = 2'd1,
        ST_ABORT   = 2'd2
    } t_status;

    // result tdata layout, lowest bit first
    localparam int unsigned OUT_FIELDS_W = 8 + 8 + LEN_W + 2 + CNT_W + CNT_W;
    localparam int unsigned OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// ===== sv/kiss_frame_deframer.sv =====
// kiss frame deframer: decodes a received byte stream into payload and frame-end items
//
// slave stream: one item per accepted beat; tuser is the item kind
//   (received byte or idle timeout from an external timer), tdata the raw byte.
// master stream: zero or one result item per input item. tlast marks a frame-end
//   item (status good, discarded or aborted); tlast low is an unescaped payload
//   byte. tdata carries command, payload byte, length or position, status and the
//   two running error counters.
// path: an accepted item sits in the input register, is decoded by a single pass
//   of logic and lands in the output register, from which the master side takes it.
// throughput: one item per cycle while the output side is not stalled, set by the
//   state update between the input register and the output register.
// reset (i_rst_n low at a clock edge) clears both pipeline valid bits, both
//   counters and the framing state but the command byte, and holds s_axis_tready
//   low; the block starts unsynchronized, ignoring all up to the first frame delimiter.
// stall: while the output register holds an untaken result the input register
//   waits, and s_axis_tready drops only when both are full; items that produce
//   no result still need the output side free to pass the decode stage.
`default_nettype none

module kiss_frame_deframer
    import kiss_fd_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire  [7:0]            s_axis_tdata,   // rx_byte [7:0]
    input  wire                   s_axis_tuser,   // req_type [0]
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    // command_code [7:0], payload_byte [15:8], frame_length [24:16],
    // frame_status [26:25], malformed_count [58:27], oversized_count [90:59], zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast    // out_kind
);

    // input register
    logic       r_in_vld;
    logic       r_in_type;
    logic [7:0] r_in_byte;

    // framing state
    logic             r_in_sync, n_in_sync;
    logic             r_have_cmd, n_have_cmd;
    logic             r_esc, n_esc;
    logic             r_discard, n_discard;
    logic [7:0]       r_cmd, n_cmd;
    logic [LEN_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_mal, n_mal;
    logic [CNT_W-1:0] r_over, n_over;

    // output register
    logic             r_out_vld;
    logic             r_out_kind, n_out_kind;
    logic [7:0]       r_out_cmd;
    logic [7:0]       r_out_byte, n_out_byte;
    logic [LEN_W-1:0] r_out_len, n_out_len;
    t_status          r_out_status, n_out_status;
    logic             n_emit;

    logic advance;
    logic step;

    // decode stage moves when the output register is empty or being drained
    assign advance       = !r_out_vld || m_axis_tready;
    assign step          = r_in_vld && advance;
    assign s_axis_tready = i_rst_n && (!r_in_vld || advance);

    always_comb begin
        logic [7:0] b;
        logic       go_payload;
        b            = r_in_byte;
        go_payload   = 1'b0;
        n_in_sync    = r_in_sync;
        n_have_cmd   = r_have_cmd;
        n_esc        = r_esc;
        n_discard    = r_discard;
        n_cmd        = r_cmd;
        n_len        = r_len;
        n_mal        = r_mal;
        n_over       = r_over;
        n_emit       = 1'b0;
        n_out_kind   = KIND_PAYLOAD;
        n_out_byte   = 8'd0;
        n_out_len    = r_len;
        n_out_status = ST_GOOD;

        if (r_in_type == REQ_TIMEOUT) begin
            // idle timeout aborts a started frame and drops sync
            if (r_have_cmd) begin
                n_mal        = r_mal + CNT_W'(1);
                n_emit       = 1'b1;
                n_out_kind   = KIND_END;
                n_out_status = ST_ABORT;
                n_in_sync    = 1'b0;
                n_have_cmd   = 1'b0;
                n_esc        = 1'b0;
                n_discard    = 1'b0;
                n_len        = '0;
            end
        end else if (r_in_byte == KISS_FEND) begin
            // delimiter: close the frame, an open escape makes it bad
            if (r_in_sync && r_have_cmd) begin
                n_emit     = 1'b1;
                n_out_kind = KIND_END;
                if (r_esc || r_discard) begin
                    n_out_len    = '0;
                    n_out_status = ST_DISCARD;
                end
            end
            if (r_esc) begin
                n_mal = r_mal + CNT_W'(1);
            end
            n_in_sync  = 1'b1;
            n_have_cmd = 1'b0;
            n_esc      = 1'b0;
            n_discard  = 1'b0;
            n_len      = '0;
        end else if (r_in_sync && !r_discard) begin
            if (!r_have_cmd) begin
                n_cmd      = r_in_byte;
                n_have_cmd = 1'b1;
            end else if (r_esc) begin
                n_esc = 1'b0;
                if (r_in_byte == KISS_TFEND) begin
                    b          = KISS_FEND;
                    go_payload = 1'b1;
                end else if (r_in_byte == KISS_TFESC) begin
                    b          = KISS_FESC;
                    go_payload = 1'b1;
                end else begin
                    // bad escape sequence
                    n_mal     = r_mal + CNT_W'(1);
                    n_discard = 1'b1;
                    n_len     = '0;
                end
            end else if (r_in_byte == KISS_FESC) begin
                n_esc = 1'b1;
            end else begin
                go_payload = 1'b1;
            end

            if (go_payload) begin
                if (r_len >= MAX_LEN) begin
                    n_over    = r_over + CNT_W'(1);
                    n_discard = 1'b1;
                    n_len     = '0;
                    n_esc     = 1'b0;
                end else begin
                    n_emit     = 1'b1;
                    n_out_byte = b;
                    n_len      = r_len + LEN_W'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_in_sync  <= 1'b0;
            r_have_cmd <= 1'b0;
            r_esc      <= 1'b0;
            r_discard  <= 1'b0;
            r_len      <= '0;
            r_mal      <= '0;
            r_over     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= step && n_emit;
            end
            if (step) begin
                r_in_sync  <= n_in_sync;
                r_have_cmd <= n_have_cmd;
                r_esc      <= n_esc;
                r_discard  <= n_discard;
                r_len      <= n_len;
                r_mal      <= n_mal;
                r_over     <= n_over;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_type <= s_axis_tuser;
            r_in_byte <= s_axis_tdata;
        end
        if (step) begin
            r_cmd <= n_cmd;
        end
        if (step && n_emit) begin
            r_out_kind   <= n_out_kind;
            r_out_cmd    <= r_cmd;
            r_out_byte   <= n_out_byte;
            r_out_len    <= n_out_len;
            r_out_status <= n_out_status;
        end
    end

    // counters shown with a result are those after its own step
    logic [CNT_W-1:0] r_out_mal;
    logic [CNT_W-1:0] r_out_over;

    always_ff @(posedge i_clk) begin
        if (step && n_emit) begin
            r_out_mal  <= n_mal;
            r_out_over <= n_over;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_kind;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_over, r_out_mal, r_out_status,
                                        r_out_len, r_out_byte, r_out_cmd});

endmodule

`default_nettype wire

// ===== sv/kiss_fd_checker.sv =====
// port-level checks for the kiss frame deframer and their bind
`default_nettype none

module kiss_fd_checker
    import kiss_fd_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  s_axis_tready,
    input wire                  m_axis_tvalid,
    input wire                  m_axis_tready,
    input wire [OUT_DATA_W-1:0] m_axis_tdata,
    input wire                  m_axis_tlast
);

    logic [LEN_W-1:0] len;
    logic [1:0]       status;

    assign len    = m_axis_tdata[24:16];
    assign status = m_axis_tdata[26:25];

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // input side is open whenever the output side can move
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
        else $error("input stalled with output side free");

    // a payload byte is good and sits below the size limit
    a_payload_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |->
            status == ST_GOOD && len < MAX_LEN)
        else $error("payload item with bad status or position");

    // a discarded frame reports no length
    a_discard_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && status == ST_DISCARD |-> len == '0)
        else $error("discarded frame with nonzero length");

endmodule

bind kiss_frame_deframer kiss_fd_checker u_kiss_fd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
